// ----- rtl/core/mf3_pkg.sv -----
// Package for the 3x3 median filter: widths, default sizes, register codes
// and the result word types shared by the filter datapath.
// Depends on nothing.
package mf3_pkg;

  localparam int MAX_LINE_DEF  = 512;
  localparam int PIXEL_W_DEF   = 16;
  localparam int POS_W         = 9;
  localparam int CFG_W         = 10;
  localparam int VALUE_W       = 16;
  localparam int POS_CAP       = 512;
  localparam int IN_TDATA_W    = 16;
  localparam int OUT_TDATA_W   = 40;
  localparam int CFG_IDX_W     = 2;
  localparam int QUEUE_DEPTH   = 8;
  localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);

  // result slots of one pixel, in output order
  localparam int SLOT_CENTER  = 0;
  localparam int SLOT_ROW_END = 1;
  localparam int SLOT_LAST    = 2;
  localparam int SLOTS        = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_ROWS = 2'd0,
    REG_IMAGE_COLS = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [POS_W-1:0]   row;
    logic [POS_W-1:0]   col;
    logic [VALUE_W-1:0] value;
    logic               eoi;
  } res_t;

  typedef struct packed {
    logic [SLOTS-1:0]     mask;
    res_t [SLOTS-1:0]     res;
  } item_t;

endpackage

// ----- rtl/core/median_filter_3x3_unit.sv -----
// Streaming 3x3 median filter over a raster-order grayscale image.
// Two line stores in synchronous RAM, a six-entry window and a
// pipelined sorting network feed a small result queue. Uses mf3_pkg.
//
// An accepted pixel passes stage registers s1 to s4, the result queue and the
// output register. Throughput: one pixel per cycle while in_tready is high and
// each pixel gives at most one result; further results wait for the single port.
// Reset (rst_n low, synchronous): clears position, pipeline, queue and window,
// sets image_rows and image_cols to 512; line stores are not cleared.
module median_filter_3x3_unit
  import mf3_pkg::*;
#(
  parameter int MAX_LINE    = MAX_LINE_DEF,
  parameter int PIXEL_WIDTH = PIXEL_W_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [15:0] pixel_value
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [8:0] out_row, [17:9] out_col,
                                             // [33:18] out_value, [39:34] zero
  output logic                   out_tlast,  // end_of_image
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  localparam int ADDR_W = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;
  localparam int IW     = (ADDR_W > POS_W) ? ADDR_W : POS_W;
  localparam int CCAP   = (MAX_LINE < POS_CAP) ? MAX_LINE : POS_CAP;
  localparam int PEND_W = QUEUE_AW + 2;
  localparam int PW     = PIXEL_WIDTH;

  function automatic logic [PW-1:0] min2(input logic [PW-1:0] a, input logic [PW-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [PW-1:0] max2(input logic [PW-1:0] a, input logic [PW-1:0] b);
    return (a < b) ? b : a;
  endfunction

  function automatic logic [PW-1:0] med3(input logic [PW-1:0] a, input logic [PW-1:0] b,
                                         input logic [PW-1:0] c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  // ---------------------------------------------------------------- config
  logic [CFG_W-1:0] rows_r, cols_r;
  logic [CFG_W-1:0] rows_eff, cols_eff;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= CFG_W'(POS_CAP);
      cols_r <= CFG_W'(POS_CAP);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_IMAGE_ROWS) rows_r <= cfg_data;
      if (cfg_index == REG_IMAGE_COLS) cols_r <= cfg_data;
    end
  end

  always_comb begin
    rows_eff = (rows_r == '0) ? CFG_W'(1) :
               ((rows_r > CFG_W'(POS_CAP)) ? CFG_W'(POS_CAP) : rows_r);
    cols_eff = (cols_r == '0) ? CFG_W'(1) :
               ((cols_r > CFG_W'(CCAP)) ? CFG_W'(CCAP) : cols_r);
  end

  // ---------------------------------------------------------------- stage 0
  logic [POS_W-1:0]  row_r, col_r;
  logic [CFG_W-1:0]  r_x, c_x;
  logic [IW-1:0]     c_w;
  logic [ADDR_W-1:0] idx0;
  logic              row_end, last_row, acc;
  item_t             item0;
  logic              med0;

  logic              s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  logic [ADDR_W-1:0] s1_idx_r;
  logic              s1_fwd_r, s1_med_r;
  logic [PW-1:0]     s1_px_r;
  item_t             s1_item_r;

  logic [PW-1:0]     older_mem [MAX_LINE];
  logic [PW-1:0]     newer_mem [MAX_LINE];
  logic [PW-1:0]     older_q, newer_q;
  logic [PW-1:0]     fw_older_r, fw_newer_r;

  assign acc = in_tvalid && in_tready;

  always_comb begin
    r_x      = CFG_W'(row_r);
    c_x      = CFG_W'(col_r);
    c_w      = IW'(col_r);
    idx0     = (c_w >= IW'(MAX_LINE - 1)) ? ADDR_W'(MAX_LINE - 1) : ADDR_W'(c_w);
    row_end  = (c_x + CFG_W'(1)) >= cols_eff;
    last_row = (r_x + CFG_W'(1)) >= rows_eff;
    med0     = (row_r >= POS_W'(2)) && (col_r >= POS_W'(2)) &&
               (r_x < rows_eff) && (c_x < cols_eff);
    item0    = '0;
    item0.mask[SLOT_CENTER]       = (row_r != '0) && (col_r != '0);
    item0.mask[SLOT_ROW_END]      = (row_r != '0) && row_end;
    item0.mask[SLOT_LAST]         = last_row;
    item0.res[SLOT_CENTER].row    = row_r - POS_W'(1);
    item0.res[SLOT_CENTER].col    = col_r - POS_W'(1);
    item0.res[SLOT_ROW_END].row   = row_r - POS_W'(1);
    item0.res[SLOT_ROW_END].col   = col_r;
    item0.res[SLOT_LAST].row      = row_r;
    item0.res[SLOT_LAST].col      = col_r;
    item0.res[SLOT_LAST].eoi      = row_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (acc) begin
      if (row_end) begin
        col_r <= '0;
        row_r <= last_row ? '0 : row_r + POS_W'(1);
      end else begin
        col_r <= col_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_idx_r  <= idx0;
      s1_fwd_r  <= s1_v_r && (s1_idx_r == idx0);
      s1_med_r  <= med0;
      s1_px_r   <= in_tdata[PW-1:0];
      s1_item_r <= item0;
    end
  end

  // line stores: read at acceptance, written back in the following cycle
  always_ff @(posedge clk) begin
    if (acc) begin
      older_q <= older_mem[idx0];
      newer_q <= newer_mem[idx0];
    end
  end

  // ---------------------------------------------------------------- stage 1
  logic [PW-1:0] up1, up2;
  logic [PW-1:0] win_r [6];
  logic [PW-1:0] w1 [9];
  item_t         item1;

  always_comb begin
    // take the values the previous word just wrote to the same entry
    up2 = s1_fwd_r ? fw_older_r : older_q;
    up1 = s1_fwd_r ? fw_newer_r : newer_q;
    w1[0] = win_r[0]; w1[1] = win_r[3]; w1[2] = up2;
    w1[3] = win_r[1]; w1[4] = win_r[4]; w1[5] = up1;
    w1[6] = win_r[2]; w1[7] = win_r[5]; w1[8] = s1_px_r;
    item1 = s1_item_r;
    item1.res[SLOT_CENTER].value  = VALUE_W'(win_r[4]);
    item1.res[SLOT_ROW_END].value = VALUE_W'(up1);
    item1.res[SLOT_LAST].value    = VALUE_W'(s1_px_r);
  end

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      older_mem[s1_idx_r] <= up1;
      newer_mem[s1_idx_r] <= s1_px_r;
      fw_older_r          <= up1;
      fw_newer_r          <= s1_px_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) win_r[i] <= '0;
    end else if (s1_v_r) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= up2;
      win_r[4] <= up1;
      win_r[5] <= s1_px_r;
    end
  end

  // ---------------------------------------------------------------- stages 2..4
  item_t         s2_item_r, s3_item_r, s4_item_r;
  logic          s2_med_r, s3_med_r, s4_med_r;
  logic [PW-1:0] s2_w_r [9];
  logic [PW-1:0] s3_lo_r [3];
  logic [PW-1:0] s3_mid_r [3];
  logic [PW-1:0] s3_hi_r [3];
  logic [PW-1:0] s4_t_r [3];
  logic [PW-1:0] median;
  item_t         item4;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_item_r <= item1;
    s2_med_r  <= s1_med_r;
    for (int i = 0; i < 9; i++) s2_w_r[i] <= w1[i];
    // sort each group of three
    s3_item_r <= s2_item_r;
    s3_med_r  <= s2_med_r;
    for (int g = 0; g < 3; g++) begin
      s3_lo_r[g]  <= min2(min2(s2_w_r[3*g], s2_w_r[3*g+1]), s2_w_r[3*g+2]);
      s3_mid_r[g] <= med3(s2_w_r[3*g], s2_w_r[3*g+1], s2_w_r[3*g+2]);
      s3_hi_r[g]  <= max2(max2(s2_w_r[3*g], s2_w_r[3*g+1]), s2_w_r[3*g+2]);
    end
    s4_item_r <= s3_item_r;
    s4_med_r  <= s3_med_r;
    s4_t_r[0] <= max2(max2(s3_lo_r[0], s3_lo_r[1]), s3_lo_r[2]);
    s4_t_r[1] <= med3(s3_mid_r[0], s3_mid_r[1], s3_mid_r[2]);
    s4_t_r[2] <= min2(min2(s3_hi_r[0], s3_hi_r[1]), s3_hi_r[2]);
  end

  always_comb begin
    median = med3(s4_t_r[0], s4_t_r[1], s4_t_r[2]);
    item4  = s4_item_r;
    if (s4_med_r) item4.res[SLOT_CENTER].value = VALUE_W'(median);
  end

  // ---------------------------------------------------------------- result queue
  item_t               q_mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wp_r, rp_r;
  logic [QUEUE_AW:0]   cnt_r;
  logic [SLOTS-1:0]    sent_r, rem, sel;
  logic [PEND_W-1:0]   pending;
  logic                push, load, pop;
  item_t               head;
  res_t                head_res;

  logic                out_v_r;
  res_t                out_res_r;

  assign push    = s4_v_r && (s4_item_r.mask != '0);
  assign pending = PEND_W'(cnt_r) + PEND_W'(s1_v_r) + PEND_W'(s2_v_r) +
                   PEND_W'(s3_v_r) + PEND_W'(s4_v_r);
  assign in_tready = pending < PEND_W'(QUEUE_DEPTH);

  always_comb begin
    head = q_mem[rp_r];
    rem  = head.mask & ~sent_r;
    sel  = '0;
    head_res = head.res[SLOT_LAST];
    priority if (rem[SLOT_CENTER]) begin
      sel[SLOT_CENTER] = 1'b1;
      head_res = head.res[SLOT_CENTER];
    end else if (rem[SLOT_ROW_END]) begin
      sel[SLOT_ROW_END] = 1'b1;
      head_res = head.res[SLOT_ROW_END];
    end else begin
      sel[SLOT_LAST] = 1'b1;
    end
    load = (cnt_r != '0) && (!out_v_r || out_tready);
    pop  = load && ((rem & ~sel) == '0);
  end

  always_ff @(posedge clk) begin
    if (push) q_mem[wp_r] <= item4;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      rp_r   <= '0;
      cnt_r  <= '0;
      sent_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + QUEUE_AW'(1);
      if (pop) begin
        rp_r   <= rp_r + QUEUE_AW'(1);
        sent_r <= '0;
      end else if (load) begin
        sent_r <= sent_r | sel;
      end
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + (QUEUE_AW + 1)'(1);
        2'b01:   cnt_r <= cnt_r - (QUEUE_AW + 1)'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (load) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_res_r <= head_res;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {(OUT_TDATA_W - 2*POS_W - VALUE_W)'(0),
                       out_res_r.value, out_res_r.col, out_res_r.row};
  assign out_tlast  = out_res_r.eoi;

`ifndef NO_ASSERTIONS
  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pending <= PEND_W'(QUEUE_DEPTH))
    else $error("result queue credit exceeded");

  a_fwd_has_writer: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s1_fwd_r) |-> s2_v_r)
    else $error("line store forward without a writing word");

  a_head_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0) |-> (rem != '0))
    else $error("queue head holds no pending result");
`endif

endmodule
